[hdl/lbd_pkg.sv]
// lbd_pkg: shared types, constants and helpers for the least-loaded bin dispatcher
// no dependencies; imported by every module under hdl

package lbd_pkg;

   localparam int DEFAULT_MAX_BINS    = 6;
   localparam int DEFAULT_WEIGHT_BITS = 16;
   localparam int DEFAULT_COUNT_BITS  = 10;

   localparam int WEIGHT_FIELD_BITS = 16;
   localparam int BIN_BITS          = 3;
   localparam int SLOT_BITS         = 10;
   localparam int SUM_BITS          = 24;
   localparam int ACTIVE_BITS       = 3;
   localparam int CSR_ADDR_BITS     = 5;
   localparam int CSR_DATA_BITS     = 32;
   localparam int NUM_CAP_REGS      = 6;

   localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 3'd6;

   // register indexes
   localparam logic [2:0] REG_ACTIVE_BINS = 3'd0;
   localparam logic [2:0] REG_CAPACITY_0  = 3'd1;

   localparam logic MODE_CLEAR = 1'b0;
   localparam logic MODE_PLACE = 1'b1;

   typedef struct packed {
      logic                         mode;
      logic [WEIGHT_FIELD_BITS-1:0] item_weight;
   } req_type;

   typedef struct packed {
      logic                 placed;
      logic [BIN_BITS-1:0]  chosen_bin;
      logic [SLOT_BITS-1:0] slot;
      logic                 halted;
      logic [SUM_BITS-1:0]  loaded_total;
      logic [SUM_BITS-1:0]  unloaded_total;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_last;
      logic out_free;
   } status_type;

   function automatic int idx_bits(int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   function automatic int win_bits(int weight_bits);
      return (weight_bits < WEIGHT_FIELD_BITS) ? weight_bits : WEIGHT_FIELD_BITS;
   endfunction

   function automatic logic [SUM_BITS-1:0] sat_add(logic [SUM_BITS-1:0] a,
                                                   logic [WEIGHT_FIELD_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + (SUM_BITS+1)'(b);
      return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
   endfunction

endpackage

[hdl/lbd_csr.sv]
// lbd_csr: configuration registers (active bin count, bin capacities) on an apb-style port
// depends on lbd_pkg

module lbd_csr
   import lbd_pkg::*;
#(
   parameter int MAX_BINS    = DEFAULT_MAX_BINS,
   parameter int WEIGHT_BITS = DEFAULT_WEIGHT_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]               csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]               csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]               csr_prdata,
   output logic [ACTIVE_BITS-1:0]                 active_bins,
   output logic [MAX_BINS-1:0][win_bits(WEIGHT_BITS)-1:0] capacity
);

   localparam int WIN = win_bits(WEIGHT_BITS);

   logic [ACTIVE_BITS-1:0]         active_ff, active_in;
   logic [MAX_BINS-1:0][WIN-1:0]   cap_ff, cap_in;
   logic [CSR_DATA_BITS-1:0]       rdata_ff, rdata_in;
   logic [2:0]                     reg_idx;
   logic                           wr_en;

   assign reg_idx = csr_paddr[4:2];
   assign wr_en   = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      active_in = active_ff;
      cap_in    = cap_ff;
      rdata_in  = rdata_ff;
      if (wr_en) begin
         if (reg_idx == REG_ACTIVE_BINS) begin
            active_in = csr_pwdata[ACTIVE_BITS-1:0];
         end
         for (int b = 0; b < MAX_BINS; b++) begin
            if (b < NUM_CAP_REGS && int'(reg_idx) == int'(REG_CAPACITY_0) + b) begin
               cap_in[b] = csr_pwdata[WIN-1:0];
            end
         end
      end
      // read data captured in the setup cycle
      if (csr_psel && !csr_penable) begin
         rdata_in = '0;
         if (reg_idx == REG_ACTIVE_BINS) begin
            rdata_in = CSR_DATA_BITS'(active_ff);
         end
         for (int b = 0; b < MAX_BINS; b++) begin
            if (b < NUM_CAP_REGS && int'(reg_idx) == int'(REG_CAPACITY_0) + b) begin
               rdata_in = CSR_DATA_BITS'(cap_ff[b]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         cap_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cap_ff    <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= rdata_in;
   end

   assign csr_prdata  = rdata_ff;
   assign active_bins = active_ff;
   assign capacity    = cap_ff;

endmodule

[hdl/lbd_ctrl.sv]
// lbd_ctrl: sequencer for accept, bin scan and commit of one item
// depends on lbd_pkg

module lbd_ctrl
   import lbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.need_scan ? ST_SCAN : ST_COMMIT;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hdl/lbd_datapath.sv]
// lbd_datapath: bin state, scan compare unit, batch totals and result register
// depends on lbd_pkg; driven by lbd_ctrl commands

module lbd_datapath
   import lbd_pkg::*;
#(
   parameter int MAX_BINS    = DEFAULT_MAX_BINS,
   parameter int WEIGHT_BITS = DEFAULT_WEIGHT_BITS,
   parameter int COUNT_BITS  = DEFAULT_COUNT_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  req_type                                req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output rsp_type                                rsp_data,
   input  logic [ACTIVE_BITS-1:0]                 active_bins,
   input  logic [MAX_BINS-1:0][win_bits(WEIGHT_BITS)-1:0] capacity,
   input  cmd_type                                cmd,
   output status_type                             status
);

   localparam int WIN      = win_bits(WEIGHT_BITS);
   localparam int FB       = WEIGHT_BITS + 1;
   localparam int IDX_BITS = idx_bits(MAX_BINS);

   logic                          item_mode_ff, item_mode_in;
   logic [WIN-1:0]                item_weight_ff, item_weight_in;
   logic                          halt_ff, halt_in;
   logic [SUM_BITS-1:0]           loaded_ff, loaded_in;
   logic [SUM_BITS-1:0]           offered_ff, offered_in;
   logic [WEIGHT_BITS-1:0]        used_ff [MAX_BINS];
   logic [WEIGHT_BITS-1:0]        used_in [MAX_BINS];
   logic [COUNT_BITS-1:0]         count_ff [MAX_BINS];
   logic [COUNT_BITS-1:0]         count_in [MAX_BINS];
   logic [IDX_BITS-1:0]           best_idx_ff, best_idx_in;
   logic [COUNT_BITS-1:0]         best_count_ff, best_count_in;
   logic signed [FB-1:0]          best_free_ff, best_free_in;
   logic [IDX_BITS-1:0]           scan_idx_ff, scan_idx_in;
   rsp_type                       out_ff, out_in;
   logic                          out_valid_ff, out_valid_in;

   logic [IDX_BITS-1:0]           last_idx;
   logic [IDX_BITS-1:0]           rd_idx;
   logic [WIN-1:0]                rd_cap;
   logic [WEIGHT_BITS-1:0]        rd_used;
   logic [COUNT_BITS-1:0]         rd_count;
   logic signed [FB-1:0]          rd_free;
   logic                          better;
   logic                          fits;

   // last bin index in use, clamped to the built bins
   always_comb begin
      if (active_bins == '0) begin
         last_idx = '0;
      end else if (int'(active_bins) > MAX_BINS) begin
         last_idx = IDX_BITS'(MAX_BINS - 1);
      end else begin
         last_idx = IDX_BITS'(active_bins - 1'b1);
      end
   end

   // single read port into the bin state
   always_comb begin
      if (cmd.commit) begin
         rd_idx = best_idx_ff;
      end else if (cmd.step) begin
         rd_idx = scan_idx_ff;
      end else begin
         rd_idx = '0;
      end
   end

   assign rd_cap   = capacity[rd_idx];
   assign rd_used  = used_ff[rd_idx];
   assign rd_count = count_ff[rd_idx];
   assign rd_free  = $signed(FB'(rd_cap)) - $signed(FB'(rd_used));

   assign better = (rd_count < best_count_ff) ||
                   ((rd_count == best_count_ff) && (rd_free > best_free_ff));
   assign fits   = $signed(FB'(item_weight_ff)) <= best_free_ff;

   assign status.need_scan = (req_data.mode == MODE_PLACE) && !halt_ff && (last_idx != '0);
   assign status.scan_last = (scan_idx_ff == last_idx);
   assign status.out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      item_mode_in   = item_mode_ff;
      item_weight_in = item_weight_ff;
      halt_in        = halt_ff;
      loaded_in      = loaded_ff;
      offered_in     = offered_ff;
      used_in        = used_ff;
      count_in       = count_ff;
      best_idx_in    = best_idx_ff;
      best_count_in  = best_count_ff;
      best_free_in   = best_free_ff;
      scan_idx_in    = scan_idx_ff;
      out_in         = out_ff;
      out_valid_in   = out_valid_ff;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      if (cmd.load) begin
         item_mode_in   = req_data.mode;
         item_weight_in = req_data.item_weight[WIN-1:0];
         best_idx_in    = '0;
         best_count_in  = rd_count;
         best_free_in   = rd_free;
         scan_idx_in    = IDX_BITS'(1);
      end

      if (cmd.step) begin
         if (better) begin
            best_idx_in   = scan_idx_ff;
            best_count_in = rd_count;
            best_free_in  = rd_free;
         end
         scan_idx_in = scan_idx_ff + 1'b1;
      end

      if (cmd.commit) begin
         out_in       = '0;
         out_valid_in = 1'b1;
         if (item_mode_ff == MODE_CLEAR) begin
            halt_in    = 1'b0;
            loaded_in  = '0;
            offered_in = '0;
            for (int b = 0; b < MAX_BINS; b++) begin
               used_in[b]  = '0;
               count_in[b] = '0;
            end
         end else if (halt_ff) begin
            offered_in = sat_add(offered_ff, WEIGHT_FIELD_BITS'(item_weight_ff));
         end else if (fits) begin
            used_in[best_idx_ff] = rd_used + WEIGHT_BITS'(item_weight_ff);
            if (best_count_ff != {COUNT_BITS{1'b1}}) begin
               count_in[best_idx_ff] = best_count_ff + 1'b1;
            end
            loaded_in         = sat_add(loaded_ff, WEIGHT_FIELD_BITS'(item_weight_ff));
            out_in.placed     = 1'b1;
            out_in.chosen_bin = BIN_BITS'(best_idx_ff);
            out_in.slot       = SLOT_BITS'(best_count_ff);
         end else begin
            halt_in    = 1'b1;
            offered_in = sat_add(offered_ff, WEIGHT_FIELD_BITS'(item_weight_ff));
         end
         out_in.halted         = halt_in;
         out_in.loaded_total   = loaded_in;
         out_in.unloaded_total = offered_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         halt_ff      <= 1'b0;
         loaded_ff    <= '0;
         offered_ff   <= '0;
         out_valid_ff <= 1'b0;
         for (int b = 0; b < MAX_BINS; b++) begin
            used_ff[b]  <= '0;
            count_ff[b] <= '0;
         end
      end else begin
         halt_ff      <= halt_in;
         loaded_ff    <= loaded_in;
         offered_ff   <= offered_in;
         out_valid_ff <= out_valid_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      item_mode_ff   <= item_mode_in;
      item_weight_ff <= item_weight_in;
      best_idx_ff    <= best_idx_in;
      best_count_ff  <= best_count_in;
      best_free_ff   <= best_free_in;
      scan_idx_ff    <= scan_idx_in;
      out_ff         <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

[hdl/least_loaded_bin_dispatcher.sv]
// least_loaded_bin_dispatcher: top level, joins csr block, sequencer and datapath
// depends on lbd_pkg, lbd_csr, lbd_ctrl, lbd_datapath
//
//   channel  ports                        direction  transfer when
//   req      req_valid req_stall req_data  in         req_valid & !req_stall
//   rsp      rsp_valid rsp_stall rsp_data  out        rsp_valid & !rsp_stall
//   csr      csr_p* (apb style)            in/out     psel & penable & pwrite
//
// a place item with n active bins is taken, then the remaining n-1 bins are scanned
// through the single compare unit, then the update is committed
// clear items and items arriving while halted skip the scan and go straight to commit
// a commit waits while the result register is full and rsp_stall is high
// synchronous reset clears all bin state and totals; active_bins resets to 6

module least_loaded_bin_dispatcher
   import lbd_pkg::*;
#(
   parameter int MAX_BINS    = DEFAULT_MAX_BINS,
   parameter int WEIGHT_BITS = DEFAULT_WEIGHT_BITS,
   parameter int COUNT_BITS  = DEFAULT_COUNT_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int WIN = win_bits(WEIGHT_BITS);

   logic [ACTIVE_BITS-1:0]       active_bins;
   logic [MAX_BINS-1:0][WIN-1:0] capacity;
   cmd_type                      cmd;
   status_type                   status;

   assign csr_pready = 1'b1;

   lbd_csr #(
      .MAX_BINS    (MAX_BINS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .active_bins (active_bins),
      .capacity    (capacity)
   );

   lbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lbd_datapath #(
      .MAX_BINS    (MAX_BINS),
      .WEIGHT_BITS (WEIGHT_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .active_bins (active_bins),
      .capacity    (capacity),
      .cmd         (cmd),
      .status      (status)
   );

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while an item is in flight");

   a_placed_not_halted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.placed && rsp_data.halted))
      else $error("result both placed and halted");

   a_halted_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.halted) |-> (rsp_data.chosen_bin == '0 && rsp_data.slot == '0))
      else $error("halted result carries a bin or slot");

   a_bin_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_data.chosen_bin) < MAX_BINS))
      else $error("chosen bin beyond built bins");

endmodule
